FILE: hw/rtl/brs_pkg.sv
// Package for the bitmap range store: word types, mode codes, controller states
// and the command and status structs between controller and datapath.
// No dependencies.
package brs_pkg;

  // Field widths fixed by the item format
  localparam int CntW  = 13;  // bit counts and range ends
  localparam int IdxW  = 12;  // bit index
  localparam int DivW  = 14;  // divider operand, holds count + word size - 1
  localparam int QuoW  = 12;  // word index and word counter
  localparam int DivShift = 20;  // reciprocal scale, exact for 14-bit operands

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_GET   = 2'd1,
    MODE_SET   = 2'd2,
    MODE_ANY   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [IdxW-1:0]   bit_index;
    logic [CntW-1:0]   range_end;
    logic              new_value;
    logic [CntW-1:0]   bit_count;
  } in_word_t;

  typedef struct packed {
    logic answer;
    logic status;
  } out_word_t;

  typedef enum logic [1:0] {
    DIV_INDEX,
    DIV_LAST,
    DIV_COUNT
  } div_sel_e;

  typedef enum logic [1:0] {
    RES_BAD,
    RES_GET,
    RES_ANY
  } res_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_B,
    ST_GOT_A,
    ST_GOT_B,
    ST_CLEAR,
    ST_READ,
    ST_GET_ANS,
    ST_SET_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic     take_item;
    div_sel_e div_sel;
    logic     set_count;
    logic     latch_first;
    logic     latch_last;
    logic     addr_zero;
    logic     addr_first;
    logic     addr_inc;
    logic     mem_read;
    logic     mem_write;
    logic     use_scan_addr;
    logic     write_zero;
    logic     acc_clr;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  index_ok;
    logic  range_ok;
    logic  scan_more;
    logic  clear_more;
    logic  out_free;
  } ctrl_sts_t;

endpackage

FILE: hw/rtl/bitmap_range_any_store.sv
// Bitmap store of WORD_BITS * WORD_COUNT bits with clear, get, set and any-in-range
// commands; one item is worked at a time. Each item goes through the two-stage
// reciprocal divider that splits bit indexes into word and bit; clear and scan walk the
// single memory port one word per cycle. A finished result waits in the output register
// while the next item is taken; a get or any whose result is ready while the previous
// one is still stalled there holds in its last step until the output register frees.
// Depends on brs_pkg, brs_ctrl and brs_datapath.
module bitmap_range_any_store #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brs_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brs_pkg::out_word_t out_word_o
);
  import brs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  brs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brs_datapath #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: hw/rtl/brs_datapath.sv
// Datapath of the bitmap range store: item register, reciprocal divider,
// word memory, range masks, result and output registers. Uses brs_pkg.
module brs_datapath #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brs_pkg::in_word_t   in_word_i,
  input  brs_pkg::ctrl_cmd_t  cmd_i,
  output brs_pkg::ctrl_sts_t  sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output brs_pkg::out_word_t  out_word_o
);
  import brs_pkg::*;

  localparam int AddrW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BitW     = $clog2(WORD_BITS);
  localparam int Capacity = WORD_BITS * WORD_COUNT;
  localparam int Recip    = ((1 << DivShift) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [31:0] RecipL = 32'(Recip);

  in_word_t              item_q;
  logic [CntW-1:0]       biu_q;
  logic [CntW-1:0]       count_sat;
  logic [DivW-1:0]       div_x, div_x_q;
  logic [31:0]           prod_q;
  logic [QuoW-1:0]       quo;
  logic [DivW-1:0]       rem_full;
  logic [QuoW-1:0]       quo_q;
  logic [BitW-1:0]       rem_q;
  logic [QuoW-1:0]       fw_q, lw_q, addr_q, data_addr_q;
  logic [BitW-1:0]       fb_q, lb_q;
  logic [WORD_BITS-1:0]  mem_q [WORD_COUNT];
  logic [WORD_BITS-1:0]  rd_data_q, set_word, wr_data, hit_bits;
  logic [AddrW-1:0]      mem_addr;
  logic                  rd_pend_q, acc_q;
  out_word_t             res_q, out_word_q;
  logic                  out_valid_q;

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) item_q <= in_word_i;
  end

  // Saturate the new bit count to the store's capacity
  always_comb begin
    if (32'(item_q.bit_count) > 32'(Capacity)) count_sat = CntW'(Capacity);
    else count_sat = item_q.bit_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) biu_q <= '0;
    else if (cmd_i.set_count) biu_q <= count_sat;
  end

  // Select the divider operand
  always_comb begin
    case (cmd_i.div_sel)
      DIV_COUNT: div_x = DivW'(count_sat) + DivW'(WORD_BITS - 1);
      DIV_LAST:  div_x = DivW'(item_q.range_end - CntW'(1));
      default:   div_x = DivW'(item_q.bit_index);
    endcase
  end

  // Divide by the word size: reciprocal multiply, then remainder
  assign quo      = prod_q[DivShift +: QuoW];
  assign rem_full = div_x_q - DivW'(32'(quo) * 32'(WORD_BITS));

  always_ff @(posedge clk_i) begin
    div_x_q <= div_x;
    prod_q  <= 32'(div_x) * RecipL;
    quo_q   <= quo;
    rem_q   <= BitW'(rem_full);
    if (cmd_i.latch_first) begin
      fw_q <= quo_q;
      fb_q <= rem_q;
    end
    if (cmd_i.latch_last) begin
      lw_q <= quo_q;
      lb_q <= rem_q;
    end
  end

  // Word counter for clear and scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) addr_q <= '0;
    else if (cmd_i.addr_zero) addr_q <= '0;
    else if (cmd_i.addr_first) addr_q <= fw_q;
    else if (cmd_i.addr_inc) addr_q <= addr_q + QuoW'(1);
  end

  // Word memory, one port shared by reads and writes
  assign mem_addr = cmd_i.use_scan_addr ? addr_q[AddrW-1:0] : fw_q[AddrW-1:0];

  always_comb begin
    set_word       = rd_data_q;
    set_word[fb_q] = item_q.new_value;
    wr_data        = cmd_i.write_zero ? '0 : set_word;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) mem_q[mem_addr] <= wr_data;
    if (cmd_i.mem_read) begin
      rd_data_q   <= mem_q[mem_addr];
      data_addr_q <= addr_q;
    end
  end

  // Mask the first and last words of the range
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      hit_bits[i] = rd_data_q[i]
                  & ((data_addr_q != fw_q) || (BitW'(i) >= fb_q))
                  & ((data_addr_q != lw_q) || (BitW'(i) <= lb_q));
    end
  end

  // Accumulate the scan one word behind the reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      acc_q     <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.mem_read & cmd_i.use_scan_addr;
      if (cmd_i.acc_clr) acc_q <= 1'b0;
      else if (rd_pend_q) acc_q <= acc_q | (|hit_bits);
    end
  end

  // Build the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_GET: res_q <= '{answer: rd_data_q[fb_q], status: 1'b0};
        RES_ANY: res_q <= '{answer: acc_q, status: 1'b0};
        default: res_q <= '{answer: 1'b0, status: 1'b1};
      endcase
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_word_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Status toward the controller
  always_comb begin
    sts_o.mode       = item_q.mode;
    sts_o.index_ok   = CntW'(item_q.bit_index) < biu_q;
    sts_o.range_ok   = (item_q.range_end > CntW'(item_q.bit_index))
                     && (item_q.range_end <= biu_q);
    sts_o.scan_more  = addr_q <= lw_q;
    sts_o.clear_more = addr_q < fw_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

FILE: hw/rtl/brs_ctrl.sv
// Controller of the bitmap range store: sequences divide, memory access,
// clear and scan loops and result hand-off. Uses brs_pkg.
module brs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brs_pkg::ctrl_sts_t  sts_i,
  output brs_pkg::ctrl_cmd_t  cmd_o
);
  import brs_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (sts_i.mode == MODE_CLEAR) begin
          cmd_o.div_sel   = DIV_COUNT;
          cmd_o.set_count = 1'b1;
        end else begin
          cmd_o.div_sel = DIV_INDEX;
        end
        state_d = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd_o.div_sel = DIV_LAST;
        state_d       = ST_GOT_A;
      end
      ST_GOT_A: begin
        cmd_o.latch_first = 1'b1;
        state_d           = ST_GOT_B;
      end
      ST_GOT_B: begin
        cmd_o.latch_last = 1'b1;
        case (sts_i.mode)
          MODE_CLEAR: begin
            cmd_o.addr_zero = 1'b1;
            state_d         = ST_CLEAR;
          end
          MODE_GET: begin
            if (sts_i.index_ok) begin
              state_d = ST_READ;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_BAD;
              state_d        = ST_RESULT;
            end
          end
          MODE_SET: begin
            state_d = sts_i.index_ok ? ST_READ : ST_IDLE;
          end
          default: begin
            if (sts_i.range_ok) begin
              cmd_o.addr_first = 1'b1;
              cmd_o.acc_clr    = 1'b1;
              state_d          = ST_SCAN;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_BAD;
              state_d        = ST_RESULT;
            end
          end
        endcase
      end
      // Zero the covering words, one a cycle
      ST_CLEAR: begin
        if (sts_i.clear_more) begin
          cmd_o.mem_write     = 1'b1;
          cmd_o.write_zero    = 1'b1;
          cmd_o.use_scan_addr = 1'b1;
          cmd_o.addr_inc      = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = (sts_i.mode == MODE_GET) ? ST_GET_ANS : ST_SET_WR;
      end
      ST_GET_ANS: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_GET;
        state_d        = ST_RESULT;
      end
      ST_SET_WR: begin
        cmd_o.mem_write = 1'b1;
        state_d         = ST_IDLE;
      end
      // Read the range's words, one a cycle
      ST_SCAN: begin
        if (sts_i.scan_more) begin
          cmd_o.mem_read      = 1'b1;
          cmd_o.use_scan_addr = 1'b1;
          cmd_o.addr_inc      = 1'b1;
        end else begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_ANY;
        state_d        = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/brs_checker.sv
// Port-level checks for the bitmap range store, bound to the top level.
// Uses brs_pkg.
module brs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input brs_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input brs_pkg::out_word_t out_word_o
);
  import brs_pkg::*;

  // A stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed or dropped");

  // An error result carries answer zero
  a_err_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status |-> !out_word_o.answer)
    else $error("error result with answer set");

  // The block is busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // A new result only appears out of work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind bitmap_range_any_store brs_checker u_brs_checker (.*);

FILE: tb/tb_top.sv
// Testbench for bitmap_range_any_store: directed and random command words with random gaps
// and output stalls, each result checked against a bit-level copy of the store.
// Depends on brs_pkg and the bitmap_range_any_store RTL.
module tb_top;
  import brs_pkg::*;

  localparam int WordBits    = 64;
  localparam int WordCount   = 64;
  localparam int Capacity    = WordBits * WordCount;
  localparam int PhaseItems  = 300;
  localparam int QuietLimit  = 4000;
  localparam int DrainCycles = 120;

  // Bit store copy, bits in use and the answers still owed by the block
  class bitmap_tracker;
    logic [WordBits-1:0] words [WordCount];
    int unsigned         in_use;
    out_word_t           expected_answers [$];
    int unsigned         fails;

    function new();
      foreach (words[i]) words[i] = '0;
      in_use = 0;
      fails  = 0;
    endfunction

    // Apply one accepted command word and queue the answer it owes
    function void note_item(in_word_t w);
      out_word_t   res;
      int unsigned idx;
      int unsigned rend;
      int unsigned k;
      idx  = w.bit_index;
      rend = w.range_end;
      res  = '0;
      case (w.mode)
        MODE_CLEAR: begin
          // saturate oversized counts, zero every word that covers the new size
          in_use = (w.bit_count > Capacity) ? Capacity : w.bit_count;
          for (k = 0; k * WordBits < in_use; k++) begin
            words[k] = '0;
          end
        end
        MODE_SET: begin
          if (idx < in_use) begin
            words[idx / WordBits][idx % WordBits] = w.new_value;
          end
        end
        MODE_GET: begin
          if (idx < in_use) begin
            res.answer = words[idx / WordBits][idx % WordBits];
          end else begin
            res.status = 1'b1;
          end
          expected_answers.push_back(res);
        end
        MODE_ANY: begin
          // empty, reversed or oversized ranges are rejected
          if (rend <= idx || rend > in_use) begin
            res.status = 1'b1;
          end else begin
            for (k = idx; k < rend; k++) begin
              if (words[k / WordBits][k % WordBits]) res.answer = 1'b1;
            end
          end
          expected_answers.push_back(res);
        end
      endcase
    endfunction

    // Compare one accepted result word with the oldest owed answer
    function void check_answer(out_word_t got);
      out_word_t want;
      if (expected_answers.size() == 0) begin
        $error("result with nothing owed: answer %0d status %0d", got.answer, got.status);
        fails++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.answer !== want.answer) begin
        $error("answer: expected %0d, got %0d", want.answer, got.answer);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n          = 1'b0;
  logic          in_valid       = 1'b0;
  logic          in_stall;
  in_word_t      in_word        = '0;
  logic          out_valid;
  logic          out_stall      = 1'b0;
  out_word_t     out_word;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   cur_count      = 0;
  int unsigned   quiet_cycles   = 0;
  bitmap_tracker tracker;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  bitmap_range_any_store #(
    .WORD_BITS (WordBits),
    .WORD_COUNT(WordCount)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Track accepted words on both sides and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_item(in_word);
      if (out_valid && !out_stall) tracker.check_answer(out_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Build one command word, idle at random, then hold it until accepted
  task automatic issue(mode_e m, int unsigned idx, int unsigned rend, bit nval,
                       int unsigned cnt);
    in_word_t w;
    w.mode      = m;
    w.bit_index = idx[IdxW-1:0];
    w.range_end = rend[CntW-1:0];
    w.new_value = nval;
    w.bit_count = cnt[CntW-1:0];
    if (m == MODE_CLEAR) begin
      cur_count = (w.bit_count > Capacity) ? Capacity : w.bit_count;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly in-range commands on the current size; clears keep sizes small
  task automatic random_item(output bit counted);
    int unsigned pick;
    int unsigned idx;
    int unsigned rend;
    int unsigned cnt;
    int unsigned len;
    bit          nval;
    mode_e       m;
    pick = $urandom_range(99);
    idx  = $urandom_range(4095);
    rend = $urandom_range(8191);
    cnt  = $urandom_range(8191);
    nval = $urandom_range(1);
    if (cur_count == 0 || pick < 6) begin
      m = MODE_CLEAR;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: cnt = $urandom_range(320, 1);
        6, 7:             cnt = $urandom_range(Capacity);
        8:                cnt = $urandom_range(8191);
        default:          cnt = $urandom_range(1) ? Capacity : 0;
      endcase
    end else if (pick < 40) begin
      m = MODE_SET;
      if ($urandom_range(9) != 0) idx = $urandom_range(cur_count - 1);
      nval = ($urandom_range(99) < 65);
    end else if (pick < 65) begin
      m = MODE_GET;
      if ($urandom_range(9) != 0) idx = $urandom_range(cur_count - 1);
    end else begin
      m = MODE_ANY;
      if ($urandom_range(9) != 0) begin
        idx = $urandom_range(cur_count - 1);
        case ($urandom_range(7))
          0, 1, 2: len = $urandom_range(4, 1);
          3, 4:    len = $urandom_range(140, 1);
          5:       len = cur_count - idx;
          6:       len = 0;
          default: len = $urandom_range(cur_count, 1);
        endcase
        rend = idx + len;
        if (rend > cur_count) begin
          rend = ($urandom_range(3) == 0) ? cur_count + 1 : cur_count;
        end
      end
    end
    counted = !(m == MODE_SET && idx >= cur_count);
    issue(m, idx, rend, nval, cnt);
  endtask

  initial begin
    int unsigned phase;
    int unsigned done;
    bit          counted;
    tracker = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty store after reset: everything is out of range
    issue(MODE_GET, 0, 0, 0, 0);
    issue(MODE_ANY, 0, 1, 0, 0);
    issue(MODE_SET, 5, 0, 1, 0);
    // Oversized clear saturates to full capacity
    issue(MODE_CLEAR, 4095, 8191, 1, 8191);
    issue(MODE_SET, 4095, 0, 1, 0);
    issue(MODE_SET, 0, 0, 1, 0);
    issue(MODE_GET, 4095, 0, 0, 0);
    issue(MODE_GET, 0, 0, 0, 0);
    issue(MODE_ANY, 0, 4096, 0, 0);
    issue(MODE_ANY, 1, 4095, 0, 0);
    issue(MODE_ANY, 4095, 4096, 0, 0);
    // Empty, reversed and oversized ranges
    issue(MODE_ANY, 5, 5, 0, 0);
    issue(MODE_ANY, 9, 3, 0, 0);
    issue(MODE_ANY, 0, 4097, 0, 0);
    issue(MODE_ANY, 4095, 8191, 0, 0);
    // Set bit seen from a range that starts on its word and one that starts past it
    issue(MODE_SET, 70, 0, 1, 0);
    issue(MODE_ANY, 64, 128, 0, 0);
    issue(MODE_ANY, 71, 200, 0, 0);
    issue(MODE_SET, 4095, 0, 0, 0);
    issue(MODE_GET, 4095, 0, 0, 0);
    // Shrink: indexes at the new size are rejected, cleared words read zero
    issue(MODE_CLEAR, 0, 0, 0, 100);
    issue(MODE_GET, 100, 0, 0, 0);
    issue(MODE_SET, 100, 0, 1, 0);
    issue(MODE_GET, 70, 0, 0, 0);
    issue(MODE_ANY, 0, 100, 0, 0);
    issue(MODE_CLEAR, 0, 0, 0, 0);
    issue(MODE_CLEAR, 0, 0, 0, 4096);

    // Random words: slow receiver, then slow sender, then full rate
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 7 : (phase == 1) ? 68 : 0;
      recv_stall_pct = (phase == 0) ? 68 : (phase == 1) ? 7 : 0;
      done = 0;
      while (done < PhaseItems) begin
        random_item(counted);
        if (counted) done++;
      end
    end
    in_valid <= 1'b0;

    // Drain owed answers, then give the last command time to settle
    while (tracker.expected_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/brs_pkg.sv
hw/rtl/brs_datapath.sv
hw/rtl/brs_ctrl.sv
hw/rtl/bitmap_range_any_store.sv
hw/rtl/brs_checker.sv
tb/tb_top.sv
